// ===== src/smpq_pkg.sv =====
// Package: shared types and constants for the stable min priority queue.
package smpq_pkg;

	localparam int DATA_W       = 32;
	localparam int PRIO_W       = 32;
	localparam int FILL_W       = 5;
	localparam int CAPACITY_DEF = 16;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	typedef struct packed {
		logic                     op;
		logic signed [DATA_W-1:0] data_in;
		logic signed [PRIO_W-1:0] prio_in;
	} smpq_in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] item_out;
		logic                     underflow;
		logic                     overflow;
		logic [FILL_W-1:0]        fill;
	} smpq_out_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] data;
		logic signed [PRIO_W-1:0] prio;
	} smpq_entry_t;

	// Broadcast from the controller to every cell.
	typedef struct packed {
		logic        ins;
		logic        rem;
		smpq_entry_t entry;
	} smpq_cmd_t;

endpackage

// ===== src/stable_min_priority_queue_unit.sv =====
// Top level: stable sorted priority queue built as a chain of compare-and-shift cells.
//
//   channel  | handshake          | payload            | notes
//   ---------+--------------------+--------------------+------------------------------
//   command  | start / busy       | cmd  (smpq_in_t)   | insert (op=0) or remove (op=1)
//   result   | done               | result (smpq_out_t)| one transaction per command
//
// No command stalls: all cells compare against the broadcast
// priority in parallel and shift in the same edge, so busy stays low and a
// command may be issued every cycle. The result appears on the cycle after
// the command is taken, with done high for exactly that cycle.
// Reset clears the entry count and the result strobe; slot contents are
// left as they are and only read below the count. The receiver cannot stall.
module stable_min_priority_queue_unit #(
	parameter int CAPACITY = smpq_pkg::CAPACITY_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  smpq_pkg::smpq_in_t  cmd,
	output logic                done,
	output smpq_pkg::smpq_out_t result
);
	import smpq_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	logic             accept;
	logic             full;
	logic             empty;
	smpq_cmd_t        bcast;
	smpq_out_t        result_q;
	logic             done_q;

	smpq_entry_t entries [CAPACITY];
	logic        gts     [CAPACITY];

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (count_q == CNT_W'(CAPACITY));
	assign empty  = (count_q == '0);

	// Drop inserts into a full chain and removes from an empty one.
	assign bcast.ins         = accept && (cmd.op == OP_INSERT) && !full;
	assign bcast.rem         = accept && (cmd.op == OP_REMOVE) && !empty;
	assign bcast.entry.data  = cmd.data_in;
	assign bcast.entry.prio  = cmd.prio_in;

	always_comb begin
		count_nxt = count_q;
		if (bcast.ins) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (bcast.rem) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	// Build the chain: each cell sees its left neighbor's compare and both neighbors' entries.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic        left_gt;
		smpq_entry_t left_entry;
		smpq_entry_t right_entry;

		if (i == 0) begin : g_head
			assign left_gt    = 1'b0;
			assign left_entry = bcast.entry;
		end else begin : g_body
			assign left_gt    = gts[i-1];
			assign left_entry = entries[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_entry = entries[i];
		end else begin : g_mid
			assign right_entry = entries[i+1];
		end

		smpq_cell u_cell (
			.clk         (clk),
			.cmd         (bcast),
			.valid       (count_q > CNT_W'(i)),
			.left_gt     (left_gt),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.entry       (entries[i]),
			.gt          (gts[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_nxt;
			done_q  <= accept;
		end
	end

	// Capture the result; the head cell still holds the removed entry this cycle.
	always_ff @(posedge clk) begin
		if (accept) begin
			result_q.item_out  <= bcast.rem ? entries[0].data : '0;
			result_q.underflow <= (cmd.op == OP_REMOVE) && empty;
			result_q.overflow  <= (cmd.op == OP_INSERT) && full;
			result_q.fill      <= FILL_W'(count_nxt);
		end
	end

	assign done   = done_q;
	assign result = result_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("accepted command produced no result");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.underflow && result.overflow))
		else $error("underflow and overflow together");

	a_underflow_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.underflow) |-> (result.fill == '0 && result.item_out == '0))
		else $error("underflow with entries held or nonzero data");

endmodule

// ===== src/smpq_cell.sv =====
// One slot of the sorted chain: compares against the broadcast priority and shifts.
module smpq_cell (
	input  logic                 clk,
	input  smpq_pkg::smpq_cmd_t  cmd,
	input  logic                 valid,
	input  logic                 left_gt,
	input  smpq_pkg::smpq_entry_t left_entry,
	input  smpq_pkg::smpq_entry_t right_entry,
	output smpq_pkg::smpq_entry_t entry,
	output logic                 gt
);
	import smpq_pkg::*;

	smpq_entry_t entry_q;

	// An empty slot sits behind everything, so it counts as greater.
	assign gt    = !valid || (entry_q.prio > cmd.entry.prio);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (cmd.ins && gt) begin
			entry_q <= left_gt ? left_entry : cmd.entry;
		end else if (cmd.rem) begin
			entry_q <= right_entry;
		end
	end

endmodule
